@@ hdl/fcull_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared widths, opcode codes and pipeline item types of the frustum culling
// core.
// ----------------------------------------------------------------------------
package fcull_pkg;

    localparam int COORD_W     = 20;   // coordinate width, 4 fraction bits
    localparam int PLANE_COUNT = 6;
    localparam int COEF_W      = 14;   // normal coefficient, signed Q1.12
    localparam int OFFS_W      = 22;   // plane offset, 4 fraction bits
    localparam int COEF_FRAC   = 12;
    localparam int RAD_W       = 19;
    localparam int DIST_W      = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int OP_W        = 2;

    // Plane register layout.
    localparam int NX_LSB   = 0;
    localparam int NY_LSB   = NX_LSB + COEF_W;
    localparam int NZ_LSB   = NY_LSB + COEF_W;
    localparam int OFFS_LSB = NZ_LSB + COEF_W;

    // One coefficient times one coordinate, at 16 fraction bits.
    localparam int PROD_W = COORD_W + COEF_W;
    // Plane value: three products plus the offset scaled by 2^12.
    localparam int SUM_W  = (PROD_W + 3 > OFFS_W + COEF_FRAC + 1) ?
                            PROD_W + 3 : OFFS_W + COEF_FRAC + 1;
    // Plane value after dropping the 12 extra fraction bits.
    localparam int QUO_W  = SUM_W - COEF_FRAC;
    localparam int SAT_W  = (QUO_W > DIST_W + 1) ? QUO_W : DIST_W + 1;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sd2147483647);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sd2147483648);

    typedef enum logic [OP_W-1:0] {
        OP_POINT  = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  lo_x;
        logic signed [COORD_W-1:0]  lo_y;
        logic signed [COORD_W-1:0]  lo_z;
        logic signed [COORD_W-1:0]  hi_x;
        logic signed [COORD_W-1:0]  hi_y;
        logic signed [COORD_W-1:0]  hi_z;
        logic        [RAD_W-1:0]    rad;
        logic                       ok;        // no plane has rejected so far
        logic                       all_in;    // every box corner in front so far
        logic signed [SUM_W-1:0]    near_val;  // first-point value of last plane
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_hop;

endpackage : fcull_pkg
`default_nettype wire

@@ hdl/fcull_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcull_in_if
// Object channel: one beat carries one point, sphere or box to test.
// ----------------------------------------------------------------------------
interface fcull_in_if;
    import fcull_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            opcode;
    logic signed [COORD_W-1:0]  first_x;
    logic signed [COORD_W-1:0]  first_y;
    logic signed [COORD_W-1:0]  first_z;
    logic signed [COORD_W-1:0]  second_x;
    logic signed [COORD_W-1:0]  second_y;
    logic signed [COORD_W-1:0]  second_z;
    logic [RAD_W-1:0]           sphere_radius;

    modport source (
        output valid, opcode, first_x, first_y, first_z,
               second_x, second_y, second_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, opcode, first_x, first_y, first_z,
               second_x, second_y, second_z, sphere_radius,
        output ready
    );
endinterface : fcull_in_if
`default_nettype wire

@@ hdl/fcull_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcull_out_if
// Result channel: one beat carries the verdict for one object.
// ----------------------------------------------------------------------------
interface fcull_out_if;
    import fcull_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      visible;
    logic                      fully_inside;
    logic signed [DIST_W-1:0]  near_distance;

    modport source (
        output valid, visible, fully_inside, near_distance,
        input  ready
    );
    modport sink (
        input  valid, visible, fully_inside, near_distance,
        output ready
    );
endinterface : fcull_out_if
`default_nettype wire

@@ hdl/fcull_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcull_cell
// One plane of the chain: holds its plane word, multiplies in a first stage
// and sums, compares and updates the running verdict in a second stage.
// ----------------------------------------------------------------------------
module fcull_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_sel,
    input  wire logic [fcull_pkg::CFG_W-1:0] i_cfg_data,
    input  wire fcull_pkg::t_hop             i_hop,
    output logic                             o_ready,
    output fcull_pkg::t_hop                  o_hop,
    input  wire logic                        i_ready
);
    import fcull_pkg::*;

    logic [CFG_W-1:0]          r_plane;
    logic signed [COEF_W-1:0]  w_nx, w_ny, w_nz;
    logic signed [OFFS_W-1:0]  w_offs;

    logic                      r_a_valid;
    t_item                     r_a_item;
    logic signed [PROD_W-1:0]  r_px_lo, r_px_hi, r_py_lo, r_py_hi, r_pz_lo, r_pz_hi;
    logic                      w_ready_a, w_ready_b;

    logic                      r_b_valid;
    t_item                     r_b_item;
    t_item                     n_item;

    logic signed [PROD_W-1:0]  w_mx, w_my, w_mz, w_lx, w_ly, w_lz;
    logic signed [SUM_W-1:0]   w_d16, w_val, w_max, w_min;
    logic signed [SUM_W:0]     w_sph;
    logic                      w_pass, w_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_sel) begin
            r_plane <= i_cfg_data;
        end
    end

    assign w_nx   = signed'(r_plane[NX_LSB +: COEF_W]);
    assign w_ny   = signed'(r_plane[NY_LSB +: COEF_W]);
    assign w_nz   = signed'(r_plane[NZ_LSB +: COEF_W]);
    assign w_offs = signed'(r_plane[OFFS_LSB +: OFFS_W]);

    assign w_ready_b = !r_b_valid || i_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    // Stage A: six products, both corners on each axis.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ready_a) begin
            r_a_valid <= i_hop.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_hop.valid) begin
            r_a_item <= i_hop.item;
            r_px_lo  <= PROD_W'(w_nx) * PROD_W'(i_hop.item.lo_x);
            r_px_hi  <= PROD_W'(w_nx) * PROD_W'(i_hop.item.hi_x);
            r_py_lo  <= PROD_W'(w_ny) * PROD_W'(i_hop.item.lo_y);
            r_py_hi  <= PROD_W'(w_ny) * PROD_W'(i_hop.item.hi_y);
            r_pz_lo  <= PROD_W'(w_nz) * PROD_W'(i_hop.item.lo_z);
            r_pz_hi  <= PROD_W'(w_nz) * PROD_W'(i_hop.item.hi_z);
        end
    end

    // Stage B: the best and worst box corners come from the per-axis larger
    // and smaller product, so eight corner values reduce to two sums.
    always_comb begin
        w_mx  = (r_px_lo > r_px_hi) ? r_px_lo : r_px_hi;
        w_my  = (r_py_lo > r_py_hi) ? r_py_lo : r_py_hi;
        w_mz  = (r_pz_lo > r_pz_hi) ? r_pz_lo : r_pz_hi;
        w_lx  = (r_px_lo > r_px_hi) ? r_px_hi : r_px_lo;
        w_ly  = (r_py_lo > r_py_hi) ? r_py_hi : r_py_lo;
        w_lz  = (r_pz_lo > r_pz_hi) ? r_pz_hi : r_pz_lo;
        w_d16 = SUM_W'(w_offs) <<< COEF_FRAC;
        w_val = SUM_W'(r_px_lo) + SUM_W'(r_py_lo) + SUM_W'(r_pz_lo) + w_d16;
        w_max = SUM_W'(w_mx) + SUM_W'(w_my) + SUM_W'(w_mz) + w_d16;
        w_min = SUM_W'(w_lx) + SUM_W'(w_ly) + SUM_W'(w_lz) + w_d16;
        w_sph = (SUM_W + 1)'(w_val)
              + signed'({1'b0, (SUM_W)'({r_a_item.rad, COEF_FRAC'(0)})});

        case (r_a_item.op)
            OP_POINT:  w_pass = !w_val[SUM_W-1] && (w_val != '0);
            OP_SPHERE: w_pass = !w_sph[SUM_W] && (w_sph != '0);
            OP_BOX:    w_pass = !w_max[SUM_W-1] && (w_max != '0);
            default:   w_pass = 1'b0;
        endcase
        w_all = !w_min[SUM_W-1] && (w_min != '0);

        n_item          = r_a_item;
        n_item.ok       = r_a_item.ok && w_pass;
        n_item.all_in   = r_a_item.all_in && w_all;
        n_item.near_val = w_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b && r_a_valid) begin
            r_b_item <= n_item;
        end
    end

    assign o_hop.valid = r_b_valid;
    assign o_hop.item  = r_b_item;

endmodule : fcull_cell
`default_nettype wire

@@ hdl/fcull_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcull_out
// Result register: forms the verdict flags and the floored, saturated
// near-plane distance at the end of the chain.
// ----------------------------------------------------------------------------
module fcull_out (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fcull_pkg::t_hop  i_hop,
    output logic                  o_ready,
    fcull_out_if.source           o_res
);
    import fcull_pkg::*;

    logic                      r_valid;
    logic                      r_visible;
    logic                      r_full;
    logic signed [DIST_W-1:0]  r_dist;

    logic                      n_full;
    logic signed [SAT_W-1:0]   w_quo;
    logic signed [DIST_W-1:0]  n_dist;

    assign o_ready = !r_valid || o_res.ready;

    always_comb begin
        case (i_hop.item.op)
            OP_POINT: n_full = i_hop.item.ok;
            OP_BOX:   n_full = i_hop.item.ok && i_hop.item.all_in;
            default:  n_full = 1'b0;
        endcase
        // Dropping the low bits of a two's complement value floors it.
        w_quo = SAT_W'(signed'(i_hop.item.near_val[SUM_W-1:COEF_FRAC]));
        if (w_quo > SAT_HI) begin
            n_dist = DIST_W'(SAT_HI);
        end else if (w_quo < SAT_LO) begin
            n_dist = DIST_W'(SAT_LO);
        end else begin
            n_dist = DIST_W'(w_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_hop.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_hop.valid) begin
            r_visible <= i_hop.item.ok;
            r_full    <= n_full;
            r_dist    <= n_dist;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.visible       = r_visible;
    assign o_res.fully_inside  = r_full;
    assign o_res.near_distance = r_dist;

endmodule : fcull_out
`default_nettype wire

@@ hdl/frustum_cull_test_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_cull_test_core
// Six-plane view frustum test of points, spheres and axis boxes, built as a
// chain of plane cells followed by a result register.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  -------   ---------  ----------------------------------------------------
//  i_obj     in         opcode, first corner/center, second corner, radius
//  o_res     out        visible, fully_inside, near_distance
//  i_cfg_*   in         plane word write, index 0..5 (right .. near)
//
//  Every beat passes through two registers in each of the six plane cells
//  (multiply, then sum and compare) and then through the result register.
//  A new beat is taken every cycle while results drain.
//  Reset clears all valid flags and sets every plane word to zero.
//  Each stage holds when the one after it is full; ready ripples back along
//  the chain, so empty stages still take beats while a result waits.
//
// ----------------------------------------------------------------------------
module frustum_cull_test_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [fcull_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fcull_pkg::CFG_W-1:0]      i_cfg_data,
    fcull_in_if.sink                              i_obj,
    fcull_out_if.source                           o_res
);
    import fcull_pkg::*;

    // Hop k enters cell k; the last hop feeds the result register. The near
    // plane is the last cell, so the distance that reaches the end of the
    // chain is the near-plane value of the first point.
    t_hop  w_hop   [PLANE_COUNT+1];
    logic  w_ready [PLANE_COUNT+1];

    always_comb begin
        w_hop[0].valid         = i_obj.valid;
        w_hop[0].item.op       = t_op'(i_obj.opcode);
        w_hop[0].item.lo_x     = i_obj.first_x;
        w_hop[0].item.lo_y     = i_obj.first_y;
        w_hop[0].item.lo_z     = i_obj.first_z;
        w_hop[0].item.hi_x     = i_obj.second_x;
        w_hop[0].item.hi_y     = i_obj.second_y;
        w_hop[0].item.hi_z     = i_obj.second_z;
        w_hop[0].item.rad      = i_obj.sphere_radius;
        // The reserved opcode is never visible.
        w_hop[0].item.ok       = (t_op'(i_obj.opcode) != OP_RSVD);
        w_hop[0].item.all_in   = 1'b1;
        w_hop[0].item.near_val = '0;
    end

    assign i_obj.ready = w_ready[0];

    for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
        fcull_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cfg_sel  (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(k))),
            .i_cfg_data (i_cfg_data),
            .i_hop      (w_hop[k]),
            .o_ready    (w_ready[k]),
            .o_hop      (w_hop[k+1]),
            .i_ready    (w_ready[k+1])
        );
    end

    fcull_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hop   (w_hop[PLANE_COUNT]),
        .o_ready (w_ready[PLANE_COUNT]),
        .o_res   (o_res)
    );

endmodule : frustum_cull_test_core
`default_nettype wire
